// ===== hdl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the lru key-value cache
// sizes of the store, field widths, opcodes and sequencer states
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESP
  } state_e;

endpackage

// ===== hdl/lkvc_if.sv =====
// ----------------------------------------------------------------------------
// lkvc_if: request and response channels of the lru key-value cache
// valid/ready handshake, a beat moves when both are high
// ----------------------------------------------------------------------------
interface lkvc_req_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [lkvc_pkg::KEY_W-1:0] lookup_key;
  logic [lkvc_pkg::VAL_W-1:0] write_value;

  modport source (output valid, output opcode, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input opcode, input lookup_key, input write_value,
                  output ready);
endinterface

interface lkvc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [lkvc_pkg::VAL_W-1:0] read_value;
  logic                       evicted;

  modport source (output valid, output hit, output read_value, output evicted,
                  input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  output ready);
endinterface

// ===== hdl/lru_key_value_cache_unit.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key-value cache, lru replacement
// get/put requests against a 16-entry store with per-entry recency ranks
// ----------------------------------------------------------------------------
// Each request beat passes through ST_IDLE, which takes the beat, ST_SCAN, in
// which a single key/rank comparator walks the key memory one entry per cycle,
// ST_DRAIN for the last registered read, ST_UPDATE, which reads or writes the
// store and shifts the recency ranks, and ST_RESP, which loads the response
// register once it is free. The request side is not ready while a request is
// in work; a finished response may wait in its output register while the next
// request is taken. The capacity register may be written only while no request
// is in flight; zero acts as one, values above ENTRIES act as ENTRIES. The
// store comes out of reset empty.
module lru_key_value_cache_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata_i,
  lkvc_req_if.sink                   req_i,
  lkvc_rsp_if.source                 rsp_o
);
  import lkvc_pkg::*;

  state_e state_q, state_d;

  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] lim_q, lim_d;
  logic [CNT_W-1:0] occ_q, occ_d;

  logic                  op_q, op_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] wval_q, wval_d;

  logic [IDX_W-1:0] scan_q, scan_d;
  logic             chk_q, chk_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;

  logic             found_q, found_d;
  logic [IDX_W-1:0] found_idx_q, found_idx_d;
  logic [IDX_W-1:0] found_rank_q, found_rank_d;
  logic             old_q, old_d;
  logic [IDX_W-1:0] old_idx_q, old_idx_d;
  logic [IDX_W-1:0] old_rank_q, old_rank_d;
  logic             free_q, free_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             ev_q, ev_d;

  logic             valid_q [ENTRIES];
  logic             valid_d [ENTRIES];
  logic [IDX_W-1:0] rank_q  [ENTRIES];
  logic [IDX_W-1:0] rank_d  [ENTRIES];

  logic                  rsp_valid_q, rsp_valid_d;
  logic                  rsp_hit_q, rsp_hit_d;
  logic [VAL_W-1:0]      rsp_val_q, rsp_val_d;
  logic                  rsp_ev_q, rsp_ev_d;

  // key and value stores
  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];
  logic [KEY_BITS-1:0]   key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic                  key_re, key_we, val_re, val_we;
  logic [IDX_W-1:0]      key_raddr, key_waddr, val_addr;
  logic [VALUE_BITS-1:0] val_wdata;

  // comparator and update helpers
  logic             chk_valid, chk_match;
  logic [IDX_W-1:0] chk_rank;
  logic             do_evict, slot_ok;
  logic [IDX_W-1:0] slot_idx;
  logic             keep;

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = rsp_hit_q;
  assign rsp_o.read_value = rsp_val_q;
  assign rsp_o.evicted    = rsp_ev_q;

  assign chk_valid = valid_q[chk_idx_q];
  assign chk_rank  = rank_q[chk_idx_q];
  assign chk_match = chk_valid && (key_rd_q == key_q);

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_d;
    end
    if (key_re) begin
      key_rd_q <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_addr] <= val_wdata;
    end
    if (val_re) begin
      val_rd_q <= val_mem[val_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      occ_q       <= '0;
      chk_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      chk_q       <= chk_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= valid_d[i];
        rank_q[i]  <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q        <= lim_d;
    op_q         <= op_d;
    key_q        <= key_d;
    wval_q       <= wval_d;
    scan_q       <= scan_d;
    chk_idx_q    <= chk_idx_d;
    found_q      <= found_d;
    found_idx_q  <= found_idx_d;
    found_rank_q <= found_rank_d;
    old_q        <= old_d;
    old_idx_q    <= old_idx_d;
    old_rank_q   <= old_rank_d;
    free_q       <= free_d;
    free_idx_q   <= free_idx_d;
    ev_q         <= ev_d;
    rsp_hit_q    <= rsp_hit_d;
    rsp_val_q    <= rsp_val_d;
    rsp_ev_q     <= rsp_ev_d;
  end

  always_comb begin
    state_d      = state_q;
    lim_d        = lim_q;
    occ_d        = occ_q;
    op_d         = op_q;
    key_d        = key_q;
    wval_d       = wval_q;
    scan_d       = scan_q;
    chk_d        = chk_q;
    chk_idx_d    = chk_idx_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    found_rank_d = found_rank_q;
    old_d        = old_q;
    old_idx_d    = old_idx_q;
    old_rank_d   = old_rank_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    ev_d         = ev_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_hit_d    = rsp_hit_q;
    rsp_val_d    = rsp_val_q;
    rsp_ev_d     = rsp_ev_q;
    key_re       = 1'b0;
    key_we       = 1'b0;
    key_raddr    = scan_q;
    key_waddr    = free_idx_q;
    val_re       = 1'b0;
    val_we       = 1'b0;
    val_addr     = found_idx_q;
    val_wdata    = wval_q;
    do_evict     = 1'b0;
    slot_ok      = 1'b0;
    slot_idx     = free_idx_q;
    keep         = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_d[i] = valid_q[i];
      rank_d[i]  = rank_q[i];
    end

    // shared comparator: one entry per cycle, in the cycle after its key read
    if (chk_q) begin
      if (chk_match && !found_q) begin
        found_d      = 1'b1;
        found_idx_d  = chk_idx_q;
        found_rank_d = chk_rank;
      end
      if (chk_valid && (!old_q || (chk_rank > old_rank_q))) begin
        old_d      = 1'b1;
        old_idx_d  = chk_idx_q;
        old_rank_d = chk_rank;
      end
      if (!chk_valid && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = chk_idx_q;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          op_d    = req_i.opcode;
          key_d   = req_i.lookup_key[KEY_BITS-1:0];
          wval_d  = req_i.write_value[VALUE_BITS-1:0];
          scan_d  = '0;
          chk_d   = 1'b0;
          found_d = 1'b0;
          old_d   = 1'b0;
          free_d  = 1'b0;
          ev_d    = 1'b0;
          if (cap_q == '0) begin
            lim_d = CNT_W'(1);
          end else if (int'(cap_q) > ENTRIES) begin
            lim_d = CNT_W'(ENTRIES);
          end else begin
            lim_d = CNT_W'(cap_q);
          end
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        key_re    = 1'b1;
        chk_d     = 1'b1;
        chk_idx_d = scan_q;
        scan_d    = scan_q + IDX_W'(1);
        if (scan_q == IDX_W'(ENTRIES - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        chk_d   = 1'b0;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (found_q) begin
          val_addr = found_idx_q;
          if (op_q == OP_GET) begin
            val_re = 1'b1;
          end else begin
            val_we = 1'b1;
          end
          // move the hit entry to the front, newer entries age by one
          for (int i = 0; i < ENTRIES; i++) begin
            if (IDX_W'(i) == found_idx_q) begin
              rank_d[i] = '0;
            end else if (valid_q[i] && (rank_q[i] < found_rank_q)) begin
              rank_d[i] = rank_q[i] + IDX_W'(1);
            end
          end
        end else if (op_q == OP_PUT) begin
          do_evict = (occ_q >= lim_q) && old_q;
          slot_ok  = free_q || do_evict;
          // lowest free slot once the victim is gone
          if (do_evict && (!free_q || (old_idx_q < free_idx_q))) begin
            slot_idx = old_idx_q;
          end else begin
            slot_idx = free_idx_q;
          end
          ev_d = do_evict;
          for (int i = 0; i < ENTRIES; i++) begin
            keep = valid_q[i] && !(do_evict && (IDX_W'(i) == old_idx_q));
            if (slot_ok && (IDX_W'(i) == slot_idx)) begin
              valid_d[i] = 1'b1;
              rank_d[i]  = '0;
            end else if (keep) begin
              valid_d[i] = 1'b1;
              if (slot_ok) begin
                rank_d[i] = rank_q[i] + IDX_W'(1);
              end
            end else begin
              valid_d[i] = 1'b0;
              if (do_evict && (IDX_W'(i) == old_idx_q)) begin
                rank_d[i] = '0;
              end
            end
          end
          if (slot_ok) begin
            key_we    = 1'b1;
            key_waddr = slot_idx;
            val_we    = 1'b1;
            val_addr  = slot_idx;
          end
          occ_d = occ_q - CNT_W'(do_evict) + CNT_W'(slot_ok);
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_hit_d   = found_q;
          rsp_ev_d    = ev_q;
          if (found_q && (op_q == OP_GET)) begin
            rsp_val_d = VAL_W'(val_rd_q);
          end else begin
            rsp_val_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/lkvc_checker.sv =====
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks of the lru key-value cache
// watches the request and response ports only
// ----------------------------------------------------------------------------
module lkvc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic                       rsp_hit_i,
  input logic [lkvc_pkg::VAL_W-1:0] rsp_read_value_i,
  input logic                       rsp_evicted_i
);
  import lkvc_pkg::*;

  // a response beat that is not taken stays valid with its read value unchanged
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_read_value_i))
    else $error("response beat dropped or changed while stalled");

  // one request at a time: no new beat right after one was taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request side ready again right after a beat");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_hit_i && rsp_evicted_i))
    else $error("response shows hit and eviction together");

  // data comes back only from a hit
  a_data_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_read_value_i != '0) |-> rsp_hit_i && !rsp_evicted_i)
    else $error("read value without a get hit");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_hit_i        (rsp_o.hit),
  .rsp_read_value_i (rsp_o.read_value),
  .rsp_evicted_i    (rsp_o.evicted)
);
